// ===== rtl/core/modexp_pkg.sv =====
// Shared constants, types and control structs for the modular exponentiation unit.
`default_nettype none

package modexp_pkg;

	localparam int BASE_BITS     = 63;
	localparam int EXP_BITS      = 63;
	localparam int MOD_BITS      = 32;
	localparam int RESULT_BITS   = 32;
	// Width of a bit counter that indexes the longest serial operand.
	localparam int CNT_BITS      = $clog2(BASE_BITS);
	localparam int EXP_CNT_BITS  = $clog2(EXP_BITS);
	localparam int IN_DATA_BITS  = ((BASE_BITS + EXP_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;
	localparam int APB_ADDR_BITS = 3;

	localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(32'd1000000007);

	// Register indexes on the configuration port.
	localparam logic REG_MODULUS = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_OUT
	} state_t;

	// Request to the serial modular multiplier.
	typedef struct packed {
		logic                 start;
		logic [MOD_BITS-1:0]  x;
		logic [BASE_BITS-1:0] y;
		logic [CNT_BITS-1:0]  last_idx;
		logic [MOD_BITS:0]    m;
	} mul_req_t;

	// Status from the serial modular multiplier.
	typedef struct packed {
		logic                done;
		logic [MOD_BITS-1:0] result;
	} mul_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/modexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: x * y mod m, one bit of y per cycle.
`default_nettype none

module modexp_mulmod
	import modexp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mul_req_t  req,
	output mul_stat_t      stat
);

	logic [MOD_BITS-1:0]  acc_q;
	logic [MOD_BITS-1:0]  x_q;
	logic [BASE_BITS-1:0] y_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [MOD_BITS+2:0] t;
	logic [MOD_BITS+2:0] m1;
	logic [MOD_BITS+2:0] m2;
	logic [MOD_BITS-1:0] acc_next;

	// acc < m and x <= m, so 2*acc + x < 3m and at most two subtractions of m are needed.
	always_comb begin
		t  = {2'b00, acc_q, 1'b0} + (y_q[BASE_BITS-1] ? {3'b000, x_q} : '0);
		m1 = {2'b00, req.m};
		m2 = {1'b0, req.m, 1'b0};
		if (t >= m2) begin
			acc_next = MOD_BITS'(t - m2);
		end else if (t >= m1) begin
			acc_next = MOD_BITS'(t - m1);
		end else begin
			acc_next = MOD_BITS'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.last_idx;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			x_q   <= req.x;
			y_q   <= req.y;
		end else if (busy_q) begin
			acc_q <= acc_next;
			y_q   <= {y_q[BASE_BITS-2:0], 1'b0};
		end
	end

	assign stat.done   = done_q;
	assign stat.result = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit: stream ports, modulus register and sequencer.
//
// The slave stream carries one word per job: base and exponent. The master stream returns
// one word, base to the exponent modulo the modulus register, which is written over APB at
// byte address 0 (0 means 2^32); the user must write it only while idle, which is not enforced.
//
// Jobs run one at a time. s_tready is high only while the sequencer is idle. The base is first
// reduced by the serial multiplier, then every exponent bit, most significant first, costs one
// serial squaring and, where the bit is set, one serial multiply by the reduced base. A zero
// exponent skips these steps and returns 1. The sequencer returns to idle as it loads the
// output register, so the next job can be accepted while m_tvalid is high.
//
// The result sits in an output register. If the receiver stalls, a finished job waits there,
// and a following job runs but holds its result until the register is free.
// Reset clears the sequencer and the output valid and sets the modulus to 1000000007.
`default_nettype none

module modular_exponentiation_unit
	import modexp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// s_tdata fields from bit 0 up: base[62:0], exponent[125:63], zero fill
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
	// m_tdata fields from bit 0 up: power_mod[31:0]
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0]      m_tdata,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]              pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [MOD_BITS-1:0]     modulus_q;
	state_t                  state_q, state_d;
	logic [EXP_BITS-1:0]     exp_q;
	logic [EXP_CNT_BITS-1:0] bit_q;
	logic [MOD_BITS-1:0]     r_q;
	logic [MOD_BITS-1:0]     bred_q;
	logic [RESULT_BITS-1:0]  out_q;
	logic                    out_valid_q;

	mul_req_t  req;
	mul_stat_t stat;

	logic                 accept;
	logic                 out_free;
	logic                 load_out;
	logic [MOD_BITS:0]    m_full;
	logic [MOD_BITS-1:0]  r_init;
	logic [BASE_BITS-1:0] in_base;
	logic [EXP_BITS-1:0]  in_exp;

	// Exponent bit step actions decided in the sequencer.
	logic                 set_r;
	logic                 set_bred;
	logic                 step_exp;
	logic                 load_exp;
	logic [MOD_BITS-1:0]  r_new;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MODULUS)) begin
			modulus_q <= pwdata[MOD_BITS-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MODULUS) ? 32'(modulus_q) : '0;

	assign in_base  = s_tdata[BASE_BITS-1:0];
	assign in_exp   = s_tdata[BASE_BITS+EXP_BITS-1:BASE_BITS];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_full   = {(modulus_q == '0), modulus_q};
	// 1 mod m is zero only for a modulus of one.
	assign r_init   = (modulus_q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

	always_comb begin
		state_d      = state_q;
		req.start    = 1'b0;
		req.x        = stat.result;
		req.y        = {stat.result, (BASE_BITS-MOD_BITS)'(0)};
		req.last_idx = CNT_BITS'(MOD_BITS - 1);
		req.m        = m_full;
		set_r        = 1'b0;
		set_bred     = 1'b0;
		step_exp     = 1'b0;
		load_exp     = 1'b0;
		load_out     = 1'b0;
		r_new        = stat.result;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					load_exp = 1'b1;
					if (in_exp == '0) begin
						set_r   = 1'b1;
						r_new   = MOD_BITS'(1);
						state_d = ST_OUT;
					end else begin
						req.start    = 1'b1;
						req.x        = MOD_BITS'(1);
						req.y        = in_base;
						req.last_idx = CNT_BITS'(BASE_BITS - 1);
						state_d      = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (stat.done) begin
					set_bred  = 1'b1;
					set_r     = 1'b1;
					r_new     = r_init;
					req.start = 1'b1;
					req.x     = r_init;
					req.y     = {r_init, (BASE_BITS-MOD_BITS)'(0)};
					state_d   = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (stat.done) begin
					set_r = 1'b1;
					if (exp_q[EXP_BITS-1]) begin
						req.start = 1'b1;
						req.y     = {bred_q, (BASE_BITS-MOD_BITS)'(0)};
						state_d   = ST_MULT;
					end else begin
						step_exp = 1'b1;
						if (bit_q == '0) begin
							state_d = ST_OUT;
						end else begin
							req.start = 1'b1;
							state_d   = ST_SQUARE;
						end
					end
				end
			end
			ST_MULT: begin
				if (stat.done) begin
					set_r    = 1'b1;
					step_exp = 1'b1;
					if (bit_q == '0) begin
						state_d = ST_OUT;
					end else begin
						req.start = 1'b1;
						state_d   = ST_SQUARE;
					end
				end
			end
			ST_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_exp) begin
			exp_q <= in_exp;
			bit_q <= EXP_CNT_BITS'(EXP_BITS - 1);
		end else if (step_exp) begin
			exp_q <= {exp_q[EXP_BITS-2:0], 1'b0};
			bit_q <= bit_q - 1'b1;
		end
		if (set_r) begin
			r_q <= r_new;
		end
		if (set_bred) begin
			bred_q <= stat.result;
		end
		if (load_out) begin
			out_q <= RESULT_BITS'(r_q);
		end
	end

	modexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_BITS'(out_q);

endmodule

`default_nettype wire
